[hdl/srtf_pkg.sv]
// Package for the SRTF scheduler: sizing constants, codes, FSM states and
// the candidate record passed down the cell chain. No dependencies.
package srtf_pkg;

  localparam int unsigned MAX_PROCESSES = 16;

  localparam int unsigned IDX_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned LIM_W   = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned CMP_W   = (LIM_W > 5) ? LIM_W : 5;
  localparam int unsigned SEL_W   = (IDX_W > 4) ? IDX_W : 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TAB_W   = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned PC_W    = 5;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [PC_W-1:0]   PC_RESET  = PC_W'(16);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Best slot seen so far as the scan walks the chain.
  typedef struct packed {
    logic             found;
    logic [TAB_W-1:0] rem;
    logic [TAB_W-1:0] arr;
    logic [TAB_W-1:0] bur;
    logic [IDX_W-1:0] idx;
  } cand_t;

endpackage

[hdl/srtf_cell.sv]
// One process slot: arrival, burst and remaining time, plus one stage of the
// minimum-remaining search chain. Depends on srtf_pkg.
module srtf_cell
  import srtf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic              act_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic              wr_i,
  input  logic [TAB_W-1:0]  arr_wr_i,
  input  logic [TAB_W-1:0]  bur_wr_i,
  input  logic              dec_i,
  input  cand_t             cand_i,
  output cand_t             cand_o
);

  logic [TAB_W-1:0] arr_q;
  logic [TAB_W-1:0] bur_q;
  logic [TAB_W-1:0] rem_q, rem_d;
  cand_t            cand_q, cand_d;
  logic             ready;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      arr_q <= arr_wr_i;
      bur_q <= bur_wr_i;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (wr_i) begin
      rem_d = bur_wr_i;
    end else if (dec_i) begin
      rem_d = rem_q - TAB_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // Strict less-than keeps the lower index on ties.
  assign ready = act_i && (rem_q != '0) && (TIME_W'(arr_q) <= now_i);

  always_comb begin
    cand_d = cand_i;
    if (ready && (!cand_i.found || (rem_q < cand_i.rem))) begin
      cand_d.found = 1'b1;
      cand_d.rem   = rem_q;
      cand_d.arr   = arr_q;
      cand_d.bur   = bur_q;
      cand_d.idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

[hdl/srtf_preemptive_scheduler.sv]
// Top level of the SRTF scheduler: control FSM, clock/counters, the chain
// of srtf_cell slots and the result register. Depends on srtf_pkg, srtf_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   a load (operation_i = 0) writes slot_i's arrival and burst times, a tick
//   (operation_i = 1) runs one scheduling quantum. A transaction is taken at
//   an edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) returns one result per tick;
//   loads give none.
//   A load writes its slot at the edge that accepts it. A tick walks a
//   candidate through the chain of MAX_PROCESSES cells, one cell per cycle,
//   in ST_SCAN, then commits in ST_COMMIT and returns to ST_IDLE; no new
//   item is taken until the tick has committed.
//   A finished result waits in the output register while a new item is taken;
//   if the receiver still stalls when the next tick is ready to commit, the
//   commit holds until the register frees up. Reset clears remaining times,
//   time, completed count and output valid, and sets process_count to 16.
//   cfg_we_i writes process_count: the user must keep it to idle (unchecked).
module srtf_preemptive_scheduler
  import srtf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PC_W-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [3:0]        slot_i,
  input  logic [TAB_W-1:0]  arrival_time_i,
  input  logic [TAB_W-1:0]  burst_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ran_o,
  output logic [3:0]        process_index_o,
  output logic              finished_o,
  output logic [TIME_W-1:0] completion_time_o,
  output logic [TIME_W-1:0] turnaround_time_o,
  output logic [TIME_W-1:0] waiting_time_o,
  output logic              all_done_o,
  output logic [TIME_W-1:0] current_time_o
);

  state_e state_q, state_d;
  logic [IDX_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic [PC_W-1:0]   pc_q;
  logic [TIME_W-1:0] time_q;
  logic [CNT_W-1:0]  done_cnt_q, done_cnt_d;
  logic [CMP_W-1:0]  limit;
  logic              in_fire, load_fire, tick_fire, commit_fire;

  cand_t chain [MAX_PROCESSES+1];
  cand_t best;

  logic [MAX_PROCESSES-1:0] wr_sel, act, dec;

  logic              out_valid_q;
  logic              ran_q, finished_q, all_done_q;
  logic [3:0]        pidx_q;
  logic [TIME_W-1:0] ct_q, tat_q, wt_q, now_q;

  logic              fin;
  logic [TIME_W-1:0] ct, tat, wt;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign load_fire   = in_fire && (operation_i == OP_LOAD);
  assign tick_fire   = in_fire && (operation_i == OP_TICK);
  assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  assign limit = (CMP_W'(pc_q) > CMP_W'(MAX_PROCESSES)) ? CMP_W'(MAX_PROCESSES)
                                                         : CMP_W'(pc_q);

  // FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_fire) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt_q == IDX_W'(MAX_PROCESSES - 1)) begin
          scan_cnt_d = '0;
          state_d    = ST_COMMIT;
        end else begin
          scan_cnt_d = scan_cnt_q + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        if (commit_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell chain
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
    assign wr_sel[g] = load_fire && (SEL_W'(slot_i) == SEL_W'(g));
    assign act[g]    = (CMP_W'(g) < limit);
    assign dec[g]    = commit_fire && best.found && (best.idx == IDX_W'(g));

    srtf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IDX_W'(g)),
      .act_i    (act[g]),
      .now_i    (time_q),
      .wr_i     (wr_sel[g]),
      .arr_wr_i (arrival_time_i),
      .bur_wr_i (burst_time_i),
      .dec_i    (dec[g]),
      .cand_i   (chain[g]),
      .cand_o   (chain[g+1])
    );
  end

  assign best = chain[MAX_PROCESSES];

  // Commit arithmetic
  assign fin = best.found && (best.rem == TAB_W'(1));
  assign ct  = (time_q == TIME_MAX) ? TIME_MAX : time_q + TIME_W'(1);
  assign tat = ct - TIME_W'(best.arr);
  assign wt  = (tat >= TIME_W'(best.bur)) ? tat - TIME_W'(best.bur) : '0;

  always_comb begin
    done_cnt_d = done_cnt_q;
    if (fin && (done_cnt_q != COUNT_MAX)) begin
      done_cnt_d = done_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PC_RESET;
      time_q     <= '0;
      done_cnt_q <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_data_i;
      if (commit_fire) begin
        done_cnt_q <= done_cnt_d;
        if (time_q != TIME_MAX) time_q <= time_q + TIME_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_fire) begin
      ran_q      <= best.found;
      pidx_q     <= best.found ? 4'(best.idx) : 4'd0;
      finished_q <= fin;
      ct_q       <= fin ? ct  : '0;
      tat_q      <= fin ? tat : '0;
      wt_q       <= fin ? wt  : '0;
      all_done_q <= (CMP_W'(done_cnt_d) == limit);
      now_q      <= time_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ran_o             = ran_q;
  assign process_index_o   = pidx_q;
  assign finished_o        = finished_q;
  assign completion_time_o = ct_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wt_q;
  assign all_done_o        = all_done_q;
  assign current_time_o    = now_q;

`ifndef SYNTH
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("result appeared without a commit");

  a_finished_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> ran_o)
    else $error("finished without a running slot");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (time_q >= $past(time_q)))
    else $error("time went backwards");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (scan_cnt_q == '0))
    else $error("scan counter not cleared outside scan");
`endif

endmodule

[tb/srtf_preemptive_scheduler_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for srtf_preemptive_scheduler: a directed table, then random
// load/tick traffic with idle gaps on both channels. Depends on srtf_pkg and the DUT.
module srtf_preemptive_scheduler_tb
  import srtf_pkg::*;
();

  localparam int unsigned SETTLE_CYCLES  = MAX_PROCESSES + 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_PHASES     = 6;

  typedef struct packed {
    logic             op;
    logic [3:0]       slot;
    logic [TAB_W-1:0] arr;
    logic [TAB_W-1:0] bur;
  } sched_item_t;

  typedef struct packed {
    logic              ran;
    logic [3:0]        idx;
    logic              fin;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              all_done;
    logic [TIME_W-1:0] cur;
  } tick_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [PC_W-1:0] cfg_val;
    sched_item_t  item;
    logic         has_typed;
    tick_result_t typed;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [PC_W-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              operation_i = 1'b0;
  logic [3:0]        slot_i = '0;
  logic [TAB_W-1:0]  arrival_time_i = '0;
  logic [TAB_W-1:0]  burst_time_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ran_o;
  logic [3:0]        process_index_o;
  logic              finished_o;
  logic [TIME_W-1:0] completion_time_o;
  logic [TIME_W-1:0] turnaround_time_o;
  logic [TIME_W-1:0] waiting_time_o;
  logic              all_done_o;
  logic [TIME_W-1:0] current_time_o;

  srtf_preemptive_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .slot_i            (slot_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ran_o             (ran_o),
    .process_index_o   (process_index_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .all_done_o        (all_done_o),
    .current_time_o    (current_time_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler shadow state
  logic [TAB_W-1:0]  arr_tab   [MAX_PROCESSES];
  logic [TAB_W-1:0]  burst_tab [MAX_PROCESSES];
  logic [TAB_W-1:0]  left_tab  [MAX_PROCESSES];
  logic [TIME_W-1:0] sched_time = '0;
  logic [CNT_W-1:0]  done_count = '0;
  logic [PC_W-1:0]   sched_count = PC_RESET;

  tick_result_t pending_results[$];
  dir_row_t     directed[$];
  int unsigned  err_count = 0;
  bit           sender_idle_on = 1'b1;
  bit           receiver_idle_on = 1'b1;
  int unsigned  stall_hold = 0;
  int unsigned  quiet_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      arr_tab[i]   = '0;
      burst_tab[i] = '0;
      left_tab[i]  = '0;
    end
  end

  // Applies one accepted transaction to the shadow state; ticks yield a result.
  function automatic void apply_item(input sched_item_t it, output bit has_res,
                                     output tick_result_t res);
    int unsigned lim;
    int unsigned pick;
    int unsigned i;
    logic [TAB_W-1:0]  best;
    logic [TIME_W-1:0] now;
    bit found;
    has_res = 1'b0;
    res = '0;
    if (it.op == OP_LOAD) begin
      if (it.slot < MAX_PROCESSES) begin
        arr_tab[it.slot]   = it.arr;
        burst_tab[it.slot] = it.bur;
        left_tab[it.slot]  = it.bur;
      end
      return;
    end
    lim = (sched_count > MAX_PROCESSES) ? MAX_PROCESSES : sched_count;
    now = sched_time;
    found = 1'b0;
    pick = 0;
    best = '0;
    for (i = 0; i < lim; i++) begin
      if (TIME_W'(arr_tab[i]) <= now && left_tab[i] != 0 && (!found || left_tab[i] < best)) begin
        best = left_tab[i];
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      left_tab[pick] = left_tab[pick] - 1'b1;
      if (left_tab[pick] == 0) begin
        res.fin = 1'b1;
        if (done_count != COUNT_MAX) done_count = done_count + 1'b1;
        res.ct  = (now == TIME_MAX) ? TIME_MAX : now + 1;
        res.tat = res.ct - TIME_W'(arr_tab[pick]);
        res.wt  = (res.tat >= TIME_W'(burst_tab[pick])) ? res.tat - TIME_W'(burst_tab[pick]) : '0;
      end
    end
    if (sched_time != TIME_MAX) sched_time = sched_time + 1;
    res.ran      = found;
    res.idx      = found ? pick[3:0] : 4'd0;
    res.all_done = (int'(done_count) == lim);
    res.cur      = now;
    has_res = 1'b1;
  endfunction

  function automatic dir_row_t load_row(input logic [3:0] slot, input logic [TAB_W-1:0] arr,
                                        input logic [TAB_W-1:0] bur);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = '{op: OP_LOAD, slot: slot, arr: arr, bur: bur};
    return r;
  endfunction

  function automatic dir_row_t tick_row();
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.op = OP_TICK;
    return r;
  endfunction

  function automatic dir_row_t tick_typed(input logic ran, input logic [3:0] idx,
                                          input logic fin, input logic [TIME_W-1:0] ct,
                                          input logic [TIME_W-1:0] tat,
                                          input logic [TIME_W-1:0] wt, input logic done,
                                          input logic [TIME_W-1:0] cur);
    dir_row_t r;
    r = tick_row();
    r.has_typed = 1'b1;
    r.typed = '{ran: ran, idx: idx, fin: fin, ct: ct, tat: tat, wt: wt, all_done: done, cur: cur};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [PC_W-1:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_val = value;
    return r;
  endfunction

  // Mostly well-formed loads near the current time with short bursts; some full-range noise.
  function automatic sched_item_t random_item();
    sched_item_t it;
    logic [TIME_W-1:0] base;
    it.op   = ($urandom_range(0, 99) < 60) ? OP_TICK : OP_LOAD;
    it.slot = 4'($urandom_range(0, 15));
    it.arr  = TAB_W'($urandom);
    it.bur  = TAB_W'($urandom);
    if (it.op == OP_LOAD && $urandom_range(0, 99) < 85) begin
      base = sched_time + $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0 && sched_time >= 12) base = sched_time - $urandom_range(0, 12);
      it.arr = TAB_W'(base);
      it.bur = ($urandom_range(0, 9) == 0) ? '0 : TAB_W'($urandom_range(1, 6));
    end
    return it;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (!sender_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic feed_item(input sched_item_t it, input bit use_typed,
                           input tick_result_t typed);
    int unsigned gap;
    bit has_res;
    tick_result_t res;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= it.op;
    slot_i         <= it.slot;
    arrival_time_i <= it.arr;
    burst_time_i   <= it.bur;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it, has_res, res);
    if (has_res) pending_results.push_back(use_typed ? typed : res);
  endtask

  // Loads leave no result behind, so settle for a full tick after the last one.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [PC_W-1:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sched_count = value;
  endtask

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Result checker and receiver stall pattern
  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ran", TIME_W'(want.ran), TIME_W'(ran_o));
        check_field("process_index", TIME_W'(want.idx), TIME_W'(process_index_o));
        check_field("finished", TIME_W'(want.fin), TIME_W'(finished_o));
        check_field("completion_time", want.ct, completion_time_o);
        check_field("turnaround_time", want.tat, turnaround_time_o);
        check_field("waiting_time", want.wt, waiting_time_o);
        check_field("all_done", TIME_W'(want.all_done), TIME_W'(all_done_o));
        check_field("current_time", want.cur, current_time_o);
      end
    end
    if (!receiver_idle_on) begin
      out_stall_i <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [PC_W-1:0] phase_counts [NUM_PHASES];
    logic [PC_W-1:0] count_now;
    int unsigned n_items;
    phase_counts = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd8, 5'd16};

    // Count 0 schedules nothing and all_done compares against zero; 31 clamps to 16.
    directed.push_back(tick_typed(1'b0, 4'd0, 1'b0, 0, 0, 0, 1'b0, 0));
    directed.push_back(cfg_row(5'd0));
    directed.push_back(tick_typed(1'b0, 4'd0, 1'b0, 0, 0, 0, 1'b1, 1));
    directed.push_back(load_row(4'd0, 16'd0, 16'd1));
    directed.push_back(tick_typed(1'b0, 4'd0, 1'b0, 0, 0, 0, 1'b1, 2));
    directed.push_back(cfg_row(5'd1));
    directed.push_back(tick_typed(1'b1, 4'd0, 1'b1, 4, 4, 3, 1'b1, 3));
    directed.push_back(cfg_row(5'd31));
    directed.push_back(load_row(4'd15, 16'd0, 16'd1));
    directed.push_back(load_row(4'd1, 16'hFFFF, 16'hFFFF));
    directed.push_back(tick_typed(1'b1, 4'd15, 1'b1, 5, 5, 4, 1'b0, 4));
    directed.push_back(load_row(4'd3, 16'd0, 16'd0));
    // equal remaining times: lower slot wins
    directed.push_back(load_row(4'd4, 16'd5, 16'd3));
    directed.push_back(load_row(4'd5, 16'd5, 16'd3));
    directed.push_back(tick_row());
    // shorter job arrives and preempts
    directed.push_back(load_row(4'd6, 16'd0, 16'd1));
    directed.push_back(tick_row());
    directed.push_back(tick_row());
    // reload a slot mid-run
    directed.push_back(load_row(4'd5, 16'd0, 16'd2));
    directed.push_back(tick_row());
    directed.push_back(tick_row());
    directed.push_back(tick_row());
    directed.push_back(tick_row());
    directed.push_back(cfg_row(5'd16));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) write_count(directed[k].cfg_val);
      else feed_item(directed[k].item, directed[k].has_typed, directed[k].typed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      count_now = (p == 4) ? PC_W'($urandom_range(2, 15)) : phase_counts[p];
      write_count(count_now);
      sender_idle_on   = (p % 3 != 2) && (p != 5);
      receiver_idle_on = (p % 3 != 1) && (p != 5);
      n_items = (count_now == 0) ? 20 : 116;
      for (int n = 0; n < n_items; n++) begin
        // sender holds off until the pipeline is empty
        if (p == 0 && n == n_items / 2) drain_results();
        feed_item(random_item(), 1'b0, '0);
      end
    end

    drain_results();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
